// ----- rtl/swm_pkg.sv -----
// Shared constants, control types and state codes for the sliding window median unit.
package swm_pkg;

   localparam int unsigned DefaultWindowDepth = 64;
   localparam int unsigned DefaultValueWidth  = 32;
   localparam int unsigned DefaultCountWidth  = $clog2(DefaultWindowDepth + 1);

   // fixed field widths of the channels
   localparam int unsigned InValueWidth = 32;
   localparam int unsigned MedianWidth  = 33;

   // cells per group in the median gather tree
   localparam int unsigned GroupSize = 8;

   localparam logic FuncAppend = 1'b0;
   localparam logic FuncRemove = 1'b1;

   typedef struct packed {
      logic insert;
      logic remove;
   } chain_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_APPLY  = 4'b0010,
      S_GATHER = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

endpackage

// ----- rtl/swm_req_if.sv -----
// Request channel interface: valid/ready handshake with operation and value.
interface swm_req_if;
   import swm_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           func;
   logic signed [InValueWidth-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);

endinterface

// ----- rtl/swm_rsp_if.sv -----
// Response channel interface: valid/ready handshake with median result fields.
interface swm_rsp_if #(
   parameter int unsigned COUNT_WIDTH = swm_pkg::DefaultCountWidth
);
   import swm_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [MedianWidth-1:0] median_twice;
   logic                          empty_res;
   logic                          rejected;
   logic [COUNT_WIDTH-1:0]        count;

   modport source (output valid, output median_twice, output empty_res,
                   output rejected, output count, input ready);
   modport sink   (input valid, input median_twice, input empty_res,
                   input rejected, input count, output ready);

endinterface

// ----- rtl/sliding_window_median_unit.sv -----
// Top level of the sliding window median unit: window control, arrival RAM and sorted chain.
// The unit keeps a FIFO window of up to WINDOW_DEPTH signed values (the low VALUE_WIDTH bits
// of each appended value) and, for every request transaction, returns one response
// transaction carrying twice the median of the window after the step, the count, an empty
// flag and a rejected flag (append on a full window or remove on an empty one leaves the
// window untouched). Timing: one transaction is in work at a time; an accepted request
// passes through the apply (to the chain), gather and result states, the response is
// registered in the result state, and the next request is taken only back in idle.
// A waiting response sits in the output register and does not hold off the next request;
// only a second finished result waits for it. The apply step uses the registered read of
// the oldest value from the arrival RAM for a removal, and the gather step uses the
// two-level tree, with a registered first level, that picks the middle cells out of the
// sorted chain. No clearing pass is needed after reset: the chain's valid bits clear at
// once and the arrival RAM data is only used from written entries.
module sliding_window_median_unit #(
   parameter int unsigned WINDOW_DEPTH = swm_pkg::DefaultWindowDepth,
   parameter int unsigned VALUE_WIDTH  = swm_pkg::DefaultValueWidth
) (
   input  logic      clock,
   input  logic      reset,
   swm_req_if.sink   req_chan,
   swm_rsp_if.source rsp_chan
);
   import swm_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(WINDOW_DEPTH);
   localparam int unsigned CountWidth = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SumWidth   = VALUE_WIDTH + 1;

   // control state
   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [PtrWidth-1:0]   oldest_ff, oldest_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // captured request
   logic                          op_ff;
   logic                          rej_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;

   // response payload
   logic signed [MedianWidth-1:0] median_ff;
   logic                          empty_ff;
   logic                          rejected_ff;
   logic [CountWidth-1:0]         rsp_count_ff;

   logic req_accept;
   logic is_full;
   logic is_empty;
   logic rsp_load;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign is_full        = (count_ff == CountWidth'(WINDOW_DEPTH));
   assign is_empty       = (count_ff == '0);

   // ---------------------------------------------------------------------------------------
   // Arrival RAM: written at accept time for a good append; always reading the oldest slot,
   // so its data is ready in the apply cycle of a removal.
   // ---------------------------------------------------------------------------------------
   logic [CountWidth:0]    wr_sum;
   logic [PtrWidth-1:0]    wr_addr;
   logic                   wr_en;
   logic [VALUE_WIDTH-1:0] ram_rdata;

   assign wr_sum = {1'b0, count_ff} + (CountWidth + 1)'(oldest_ff);

   always_comb begin
      if (wr_sum >= (CountWidth + 1)'(WINDOW_DEPTH)) begin
         wr_addr = PtrWidth'(wr_sum - (CountWidth + 1)'(WINDOW_DEPTH));
      end else begin
         wr_addr = PtrWidth'(wr_sum);
      end
   end

   assign wr_en = req_accept && (req_chan.func == FuncAppend) && !is_full;

   swm_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_arrival_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value[VALUE_WIDTH-1:0]),
      .rd_addr (oldest_ff),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------------------------
   // Sorted chain: updated at most once per transaction, in the apply cycle
   // ---------------------------------------------------------------------------------------
   chain_ctrl_type                chain_ctrl;
   logic signed [VALUE_WIDTH-1:0] chain_x;
   logic [CountWidth-1:0]         half_count;
   logic [PtrWidth-1:0]           hi_idx;
   logic [PtrWidth-1:0]           lo_idx;
   logic signed [VALUE_WIDTH-1:0] lo_val;
   logic signed [VALUE_WIDTH-1:0] hi_val;

   assign chain_ctrl.insert = (state_ff == S_APPLY) && (op_ff == FuncAppend) && !rej_ff;
   assign chain_ctrl.remove = (state_ff == S_APPLY) && (op_ff == FuncRemove) && !rej_ff;
   assign chain_x           = (op_ff == FuncRemove) ? $signed(ram_rdata) : value_ff;

   // middle cells: odd count takes the center twice, even count the two around it
   assign half_count = count_ff >> 1;
   assign hi_idx     = PtrWidth'(half_count);
   assign lo_idx     = count_ff[0] ? hi_idx : (hi_idx - PtrWidth'(1));

   swm_chain #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (chain_ctrl),
      .x      (chain_x),
      .lo_idx (lo_idx),
      .hi_idx (hi_idx),
      .lo_val (lo_val),
      .hi_val (hi_val)
   );

   logic signed [SumWidth-1:0] median_sum;
   assign median_sum = SumWidth'(lo_val) + SumWidth'(hi_val);

   // ---------------------------------------------------------------------------------------
   // Sequencer and window pointers
   // ---------------------------------------------------------------------------------------
   assign rsp_load = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      oldest_in = oldest_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (chain_ctrl.insert) begin
               count_in = count_ff + CountWidth'(1);
            end else if (chain_ctrl.remove) begin
               count_in = count_ff - CountWidth'(1);
               if (oldest_ff == PtrWidth'(WINDOW_DEPTH - 1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + PtrWidth'(1);
               end
            end
            state_in = S_GATHER;
         end
         S_GATHER: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_chan.func;
         rej_ff   <= (req_chan.func == FuncRemove) ? is_empty : is_full;
         value_ff <= req_chan.value[VALUE_WIDTH-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         median_ff    <= is_empty ? '0 : MedianWidth'(median_sum);
         empty_ff     <= is_empty;
         rejected_ff  <= rej_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.median_twice = median_ff;
   assign rsp_chan.empty_res    = empty_ff;
   assign rsp_chan.rejected     = rejected_ff;
   assign rsp_chan.count        = rsp_count_ff;

endmodule

// ----- rtl/swm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module swm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swm_cell.sv -----
// One sorted-chain cell: holds a value and a valid bit, shifts with its neighbors.
module swm_cell #(
   parameter int unsigned VALUE_WIDTH = swm_pkg::DefaultValueWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::chain_ctrl_type       ctrl,
   input  logic signed [VALUE_WIDTH-1:0] x,
   input  logic signed [VALUE_WIDTH-1:0] left_val,
   input  logic                          left_flag,
   input  logic                          left_valid,
   input  logic signed [VALUE_WIDTH-1:0] right_val,
   input  logic                          right_valid,
   output logic                          flag,
   output logic signed [VALUE_WIDTH-1:0] val,
   output logic                          valid
);
   import swm_pkg::*;

   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic signed [VALUE_WIDTH-1:0] val_in;
   logic                          valid_ff;
   logic                          valid_in;

   // empty cells sort as +infinity; remove uses >= so the first equal copy goes
   assign flag = !valid_ff || (val_ff > x) || (ctrl.remove && (val_ff == x));

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         valid_in = left_valid;
         if (left_flag) begin
            val_in = left_val;
         end else if (flag) begin
            val_in = x;
         end
      end else if (ctrl.remove) begin
         valid_in = right_valid;
         if (flag) begin
            val_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

// ----- rtl/swm_chain.sv -----
// Row of sorted cells plus a registered gather tree that picks the two middle values.
module swm_chain #(
   parameter int unsigned WINDOW_DEPTH = swm_pkg::DefaultWindowDepth,
   parameter int unsigned VALUE_WIDTH  = swm_pkg::DefaultValueWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  swm_pkg::chain_ctrl_type         ctrl,
   input  logic signed [VALUE_WIDTH-1:0]   x,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] lo_idx,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] hi_idx,
   output logic signed [VALUE_WIDTH-1:0]   lo_val,
   output logic signed [VALUE_WIDTH-1:0]   hi_val
);
   import swm_pkg::*;

   localparam int unsigned PtrWidth  = $clog2(WINDOW_DEPTH);
   localparam int unsigned NumGroups = (WINDOW_DEPTH + GroupSize - 1) / GroupSize;

   logic signed [VALUE_WIDTH-1:0] val_w   [WINDOW_DEPTH];
   logic                          flag_w  [WINDOW_DEPTH];
   logic                          valid_w [WINDOW_DEPTH];

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_val;
      logic                          left_flag;
      logic                          left_valid;
      logic signed [VALUE_WIDTH-1:0] right_val;
      logic                          right_valid;

      if (i == 0) begin : g_head
         assign left_val   = x;
         assign left_flag  = 1'b0;
         assign left_valid = 1'b1;
      end else begin : g_left
         assign left_val   = val_w[i-1];
         assign left_flag  = flag_w[i-1];
         assign left_valid = valid_w[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_tail
         assign right_val   = val_w[i];
         assign right_valid = 1'b0;
      end else begin : g_right
         assign right_val   = val_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      swm_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .x           (x),
         .left_val    (left_val),
         .left_flag   (left_flag),
         .left_valid  (left_valid),
         .right_val   (right_val),
         .right_valid (right_valid),
         .flag        (flag_w[i]),
         .val         (val_w[i]),
         .valid       (valid_w[i])
      );
   end

   // first tree level: one masked OR per group of cells, registered
   logic [VALUE_WIDTH-1:0] grp_lo_in [NumGroups];
   logic [VALUE_WIDTH-1:0] grp_hi_in [NumGroups];
   logic [VALUE_WIDTH-1:0] grp_lo_ff [NumGroups];
   logic [VALUE_WIDTH-1:0] grp_hi_ff [NumGroups];

   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         grp_lo_in[g] = '0;
         grp_hi_in[g] = '0;
         for (int k = 0; k < GroupSize; k++) begin
            if (g * GroupSize + k < WINDOW_DEPTH) begin
               if (PtrWidth'(g * GroupSize + k) == lo_idx) begin
                  grp_lo_in[g] = grp_lo_in[g] | val_w[g * GroupSize + k];
               end
               if (PtrWidth'(g * GroupSize + k) == hi_idx) begin
                  grp_hi_in[g] = grp_hi_in[g] | val_w[g * GroupSize + k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NumGroups; g++) begin
         grp_lo_ff[g] <= grp_lo_in[g];
         grp_hi_ff[g] <= grp_hi_in[g];
      end
   end

   // second level: OR of the group results
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int g = 0; g < NumGroups; g++) begin
         lo_val = lo_val | grp_lo_ff[g];
         hi_val = hi_val | grp_hi_ff[g];
      end
   end

endmodule

// ----- rtl/swm_checker.sv -----
// Port-level checker for the sliding window median unit, bound to the top level.
module swm_checker #(
   parameter int unsigned WINDOW_DEPTH = swm_pkg::DefaultWindowDepth
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [swm_pkg::MedianWidth-1:0]   median_twice,
   input logic                                     empty_res,
   input logic [$clog2(WINDOW_DEPTH + 1)-1:0]      count
);
   import swm_pkg::*;

   localparam int unsigned CountWidth = $clog2(WINDOW_DEPTH + 1);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(median_twice) && $stable(count))
      else $error("response changed while stalled");

   // window never reports more than its depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count <= CountWidth'(WINDOW_DEPTH))
      else $error("count beyond window depth");

   // an empty window reports a zero median and a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && empty_res |-> (median_twice == '0) && (count == '0))
      else $error("empty window with nonzero median or count");

   // a nonempty window reports a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !empty_res |-> count != '0)
      else $error("nonempty flag with zero count");

endmodule

bind sliding_window_median_unit swm_checker #(
   .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .median_twice (rsp_chan.median_twice),
   .empty_res    (rsp_chan.empty_res),
   .count        (rsp_chan.count)
);
